// ===== hdl/abw_pkg.sv =====
// Shared constants, codes and types of the affine bilinear wrap resampler.
package abw_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int ALPHA_LANE_DEF = 3;

  localparam int COORD_W    = 8;   // tile size, column and row width
  localparam int SUM_W      = 50;  // Q34.16 source coordinate
  localparam int FRAC_W     = 16;
  localparam int MAG_W      = SUM_W - FRAC_W;  // integer part magnitude
  localparam int MOD_DIGITS = 4;   // bits retired per wrap stage
  localparam int MOD_STAGES = (MAG_W + MOD_DIGITS - 1) / MOD_DIGITS;
  localparam int MOD_PAD_W  = MOD_STAGES * MOD_DIGITS;
  localparam int WRAP_LAT   = MOD_STAGES + 2;
  localparam int FE_LAT     = WRAP_LAT + 4;

  localparam int LANES   = 4;
  localparam int WGT_W   = 17;
  localparam int PRD_W   = 16;
  localparam int ACC_W   = 33;
  localparam int ASUM_W  = 25;
  localparam int NUM_W   = 34;
  localparam int DEN_W   = ASUM_W + 1;
  localparam int Q_W     = 8;
  localparam int DIV_STEPS = Q_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_M00 = 3'd0,
    CFG_INV_M01 = 3'd1,
    CFG_INV_M02 = 3'd2,
    CFG_INV_M10 = 3'd3,
    CFG_INV_M11 = 3'd4,
    CFG_INV_M12 = 3'd5,
    CFG_SRC_W   = 3'd6,
    CFG_SRC_H   = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  localparam logic [CFG_DW-1:0]  INV_DIAG_RESET = 32'h0001_0000;
  localparam logic [CFG_DW-1:0]  INV_ZERO_RESET = 32'h0000_0000;
  localparam logic [COORD_W-1:0] SIZE_RESET     = 8'd128;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic ld_ok;
  } fe_ctl_t;

endpackage

// ===== hdl/affine_bilinear_wrap_resampler_top.sv =====
// Affine bilinear resampler over a tiled RGBA source image.
//
// Input channel (in_valid / in_stall): each word is a load (in_op = 0),
// which writes in_load_pixel to source address in_load_index, or a sample
// (in_op = 1), which maps (in_dest_x, in_dest_y) through the inverse
// matrix and returns one blended pixel on the output channel.
// Output channel (out_valid / out_stall): chan0..chan3 of each sample, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_index; write only
// while no item is in flight.
// Throughput: one load per cycle while no sample holds the sequencer; a new
// sample is taken only after the four neighbor reads of the last one through
// the single port of the source RAM. A sample passes 15 mapping, wrap and
// address stages, 1 issue, 4 reads, 3 blend and 8 divider stages to out_valid.
// Reset clears the pipeline and restores an identity matrix and a 128x128
// tile; the source RAM is not cleared and must be loaded before sampling.
// When out_stall holds a result, back end and sample reads freeze; loads go on;
// the front end takes words until one waits at its end, then raises in_stall.
module affine_bilinear_wrap_resampler_top #(
  parameter int MAX_WIDTH  = abw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = abw_pkg::MAX_HEIGHT_DEF,
  parameter int ALPHA_LANE = abw_pkg::ALPHA_LANE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [13:0]                   in_load_index,
  input  logic [31:0]                   in_load_pixel,
  input  logic signed [15:0]            in_dest_x,
  input  logic signed [15:0]            in_dest_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_chan0,
  output logic [7:0]                    out_chan1,
  output logic [7:0]                    out_chan2,
  output logic [7:0]                    out_chan3,
  input  logic                          cfg_we,
  input  logic [abw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abw_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic signed [31:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r;
  logic [abw_pkg::COORD_W-1:0] src_w_r, src_h_r, w_eff, h_eff;

  abw_pkg::fe_ctl_t            fe;
  logic [AW-1:0]               fe_ld_addr;
  logic [31:0]                 fe_pixel;
  logic [3:0][AW-1:0]          fe_addr;
  logic [abw_pkg::COORD_W-1:0] fe_tx, fe_ty;
  logic                        fe_take, fe_en;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r   <= abw_pkg::INV_DIAG_RESET;
      m01_r   <= abw_pkg::INV_ZERO_RESET;
      m02_r   <= abw_pkg::INV_ZERO_RESET;
      m10_r   <= abw_pkg::INV_ZERO_RESET;
      m11_r   <= abw_pkg::INV_DIAG_RESET;
      m12_r   <= abw_pkg::INV_ZERO_RESET;
      src_w_r <= abw_pkg::SIZE_RESET;
      src_h_r <= abw_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (abw_pkg::cfg_idx_t'(cfg_index))
        abw_pkg::CFG_INV_M00: m00_r   <= cfg_wdata;
        abw_pkg::CFG_INV_M01: m01_r   <= cfg_wdata;
        abw_pkg::CFG_INV_M02: m02_r   <= cfg_wdata;
        abw_pkg::CFG_INV_M10: m10_r   <= cfg_wdata;
        abw_pkg::CFG_INV_M11: m11_r   <= cfg_wdata;
        abw_pkg::CFG_INV_M12: m12_r   <= cfg_wdata;
        abw_pkg::CFG_SRC_W:   src_w_r <= cfg_wdata[abw_pkg::COORD_W-1:0];
        abw_pkg::CFG_SRC_H:   src_h_r <= cfg_wdata[abw_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // tile size forced into 1..MAX
  always_comb begin
    if (src_w_r == '0) begin
      w_eff = abw_pkg::COORD_W'(1);
    end else if (32'(src_w_r) > 32'(MAX_WIDTH)) begin
      w_eff = abw_pkg::COORD_W'(MAX_WIDTH);
    end else begin
      w_eff = src_w_r;
    end
    if (src_h_r == '0) begin
      h_eff = abw_pkg::COORD_W'(1);
    end else if (32'(src_h_r) > 32'(MAX_HEIGHT)) begin
      h_eff = abw_pkg::COORD_W'(MAX_HEIGHT);
    end else begin
      h_eff = src_h_r;
    end
  end

  assign fe_en    = !fe.valid || fe_take;
  assign in_stall = !fe_en;

  abw_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (fe_en),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_load_index (in_load_index),
    .in_load_pixel (in_load_pixel),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .m00           (m00_r),
    .m01           (m01_r),
    .m02           (m02_r),
    .m10           (m10_r),
    .m11           (m11_r),
    .m12           (m12_r),
    .size_w        (w_eff),
    .size_h        (h_eff),
    .fe            (fe),
    .fe_ld_addr    (fe_ld_addr),
    .fe_pixel      (fe_pixel),
    .fe_addr       (fe_addr),
    .fe_tx         (fe_tx),
    .fe_ty         (fe_ty)
  );

  abw_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  abw_blend #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ALPHA_LANE (ALPHA_LANE)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .fe         (fe),
    .fe_ld_addr (fe_ld_addr),
    .fe_pixel   (fe_pixel),
    .fe_addr    (fe_addr),
    .fe_tx      (fe_tx),
    .fe_ty      (fe_ty),
    .fe_take    (fe_take),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_chan0  (out_chan0),
    .out_chan1  (out_chan1),
    .out_chan2  (out_chan2),
    .out_chan3  (out_chan3)
  );

endmodule

// ===== hdl/abw_ram.sv =====
// Generic single-port RAM with registered read.
module abw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/abw_wrap.sv =====
// Pipelined floored wrap of a Q34.16 coordinate over the tile size.
module abw_wrap (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [abw_pkg::SUM_W-1:0]  coord,
  input  logic [abw_pkg::COORD_W-1:0]       size,
  output logic [abw_pkg::COORD_W-1:0]       lo,
  output logic [abw_pkg::COORD_W-1:0]       hi,
  output logic [abw_pkg::COORD_W-1:0]       frac
);

  logic [abw_pkg::COORD_W-1:0]   rem_r  [0:abw_pkg::MOD_STAGES];
  logic [abw_pkg::MOD_PAD_W-1:0] mag_r  [0:abw_pkg::MOD_STAGES];
  logic                          neg_r  [0:abw_pkg::MOD_STAGES];
  logic [abw_pkg::COORD_W-1:0]   frac_r [0:abw_pkg::MOD_STAGES];
  logic [abw_pkg::COORD_W-1:0]   rem_nxt [1:abw_pkg::MOD_STAGES];

  logic [abw_pkg::MAG_W-1:0]   ip;
  logic [abw_pkg::MAG_W-1:0]   mag0;
  logic [abw_pkg::COORD_W-1:0] fix;
  logic [abw_pkg::COORD_W:0]   inc;
  logic [abw_pkg::COORD_W-1:0] lo_r, hi_r, fout_r;

  assign ip   = coord[abw_pkg::SUM_W-1:abw_pkg::FRAC_W];
  assign mag0 = ip[abw_pkg::MAG_W-1] ? abw_pkg::MAG_W'(~ip + 1'b1) : ip;

  // restoring remainder, MOD_DIGITS bits per stage, msb first
  always_comb begin
    logic [abw_pkg::COORD_W-1:0] t;
    logic [abw_pkg::COORD_W:0]   sh;
    for (int j = 1; j <= abw_pkg::MOD_STAGES; j++) begin
      t = rem_r[j-1];
      for (int d = 0; d < abw_pkg::MOD_DIGITS; d++) begin
        sh = {t, mag_r[j-1][(abw_pkg::MOD_STAGES - j) * abw_pkg::MOD_DIGITS
                            + abw_pkg::MOD_DIGITS - 1 - d]};
        if (sh >= {1'b0, size}) begin
          t = abw_pkg::COORD_W'(sh - {1'b0, size});
        end else begin
          t = sh[abw_pkg::COORD_W-1:0];
        end
      end
      rem_nxt[j] = t;
    end
  end

  // negative: floored result is size minus a nonzero magnitude remainder
  always_comb begin
    if (neg_r[abw_pkg::MOD_STAGES] && (rem_r[abw_pkg::MOD_STAGES] != '0)) begin
      fix = size - rem_r[abw_pkg::MOD_STAGES];
    end else begin
      fix = rem_r[abw_pkg::MOD_STAGES];
    end
    inc = {1'b0, fix} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      mag_r[0]  <= abw_pkg::MOD_PAD_W'(mag0);
      neg_r[0]  <= ip[abw_pkg::MAG_W-1];
      frac_r[0] <= coord[abw_pkg::FRAC_W-1:abw_pkg::FRAC_W-abw_pkg::COORD_W];
      for (int j = 1; j <= abw_pkg::MOD_STAGES; j++) begin
        rem_r[j]  <= rem_nxt[j];
        mag_r[j]  <= mag_r[j-1];
        neg_r[j]  <= neg_r[j-1];
        frac_r[j] <= frac_r[j-1];
      end
      lo_r   <= fix;
      hi_r   <= (inc == {1'b0, size}) ? '0 : inc[abw_pkg::COORD_W-1:0];
      fout_r <= frac_r[abw_pkg::MOD_STAGES];
    end
  end

  assign lo   = lo_r;
  assign hi   = hi_r;
  assign frac = fout_r;

endmodule

// ===== hdl/abw_coord.sv =====
// Front end: affine mapping, wrap and neighbor address generation.
module abw_coord #(
  parameter int MAX_WIDTH  = abw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = abw_pkg::MAX_HEIGHT_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_op,
  input  logic [13:0]                   in_load_index,
  input  logic [31:0]                   in_load_pixel,
  input  logic signed [15:0]            in_dest_x,
  input  logic signed [15:0]            in_dest_y,
  input  logic signed [31:0]            m00,
  input  logic signed [31:0]            m01,
  input  logic signed [31:0]            m02,
  input  logic signed [31:0]            m10,
  input  logic signed [31:0]            m11,
  input  logic signed [31:0]            m12,
  input  logic [abw_pkg::COORD_W-1:0]   size_w,
  input  logic [abw_pkg::COORD_W-1:0]   size_h,
  output abw_pkg::fe_ctl_t              fe,
  output logic [AW-1:0]                 fe_ld_addr,
  output logic [31:0]                   fe_pixel,
  output logic [3:0][AW-1:0]            fe_addr,
  output logic [abw_pkg::COORD_W-1:0]   fe_tx,
  output logic [abw_pkg::COORD_W-1:0]   fe_ty
);

  localparam int L = abw_pkg::FE_LAT;

  logic              vld_r  [L];
  abw_pkg::op_t      op_r   [L];
  logic              ok_r   [L];
  logic [AW-1:0]     lda_r  [L];
  logic [31:0]       pix_r  [L];

  logic signed [15:0] dx_r, dy_r;
  logic signed [47:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [abw_pkg::SUM_W-1:0] sx_r, sy_r;
  logic [abw_pkg::COORD_W-1:0] x_lo, x_hi, x_fr, y_lo, y_hi, y_fr;
  logic [3:0][AW-1:0] addr_r;
  logic [abw_pkg::COORD_W-1:0] tx_r, ty_r;

  logic [31:0] ld_full;
  logic [31:0] row_t, row_b;
  logic [31:0] a0, a1, a2, a3;

  assign ld_full = 32'(in_load_index);
  assign row_t = 32'(y_lo) * 32'(MAX_WIDTH);
  assign row_b = 32'(y_hi) * 32'(MAX_WIDTH);
  assign a0 = row_t + 32'(x_lo);
  assign a1 = row_t + 32'(x_hi);
  assign a2 = row_b + 32'(x_lo);
  assign a3 = row_b + 32'(x_hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < L; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]  <= abw_pkg::op_t'(in_op);
      ok_r[0]  <= (ld_full < 32'(DEPTH));
      lda_r[0] <= ld_full[AW-1:0];
      pix_r[0] <= in_load_pixel;
      for (int i = 1; i < L; i++) begin
        op_r[i]  <= op_r[i-1];
        ok_r[i]  <= ok_r[i-1];
        lda_r[i] <= lda_r[i-1];
        pix_r[i] <= pix_r[i-1];
      end
      dx_r  <= in_dest_x;
      dy_r  <= in_dest_y;
      p00_r <= m00 * dx_r;
      p01_r <= m01 * dy_r;
      p10_r <= m10 * dx_r;
      p11_r <= m11 * dy_r;
      sx_r  <= abw_pkg::SUM_W'(p00_r) + abw_pkg::SUM_W'(p01_r) + abw_pkg::SUM_W'(m02);
      sy_r  <= abw_pkg::SUM_W'(p10_r) + abw_pkg::SUM_W'(p11_r) + abw_pkg::SUM_W'(m12);
      addr_r[0] <= a0[AW-1:0];
      addr_r[1] <= a1[AW-1:0];
      addr_r[2] <= a2[AW-1:0];
      addr_r[3] <= a3[AW-1:0];
      tx_r <= x_fr;
      ty_r <= y_fr;
    end
  end

  abw_wrap u_wrap_x (
    .clk   (clk),
    .en    (en),
    .coord (sx_r),
    .size  (size_w),
    .lo    (x_lo),
    .hi    (x_hi),
    .frac  (x_fr)
  );

  abw_wrap u_wrap_y (
    .clk   (clk),
    .en    (en),
    .coord (sy_r),
    .size  (size_h),
    .lo    (y_lo),
    .hi    (y_hi),
    .frac  (y_fr)
  );

  assign fe.valid   = vld_r[L-1];
  assign fe.op      = op_r[L-1];
  assign fe.ld_ok   = ok_r[L-1];
  assign fe_ld_addr = lda_r[L-1];
  assign fe_pixel   = pix_r[L-1];
  assign fe_addr    = addr_r;
  assign fe_tx      = tx_r;
  assign fe_ty      = ty_r;

endmodule

// ===== hdl/abw_blend.sv =====
// Memory sequencer, premultiplied bilinear blend, divider and output register.
module abw_blend #(
  parameter int MAX_WIDTH  = abw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = abw_pkg::MAX_HEIGHT_DEF,
  parameter int ALPHA_LANE = abw_pkg::ALPHA_LANE_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  abw_pkg::fe_ctl_t            fe,
  input  logic [AW-1:0]               fe_ld_addr,
  input  logic [31:0]                 fe_pixel,
  input  logic [3:0][AW-1:0]          fe_addr,
  input  logic [abw_pkg::COORD_W-1:0] fe_tx,
  input  logic [abw_pkg::COORD_W-1:0] fe_ty,
  output logic                        fe_take,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_addr,
  output logic [31:0]                 mem_wdata,
  input  logic [31:0]                 mem_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_chan0,
  output logic [7:0]                  out_chan1,
  output logic [7:0]                  out_chan2,
  output logic [7:0]                  out_chan3
);

  localparam int NL = abw_pkg::LANES;
  localparam int DS = abw_pkg::DIV_STEPS;

  // sequencer
  logic                        busy_r;
  abw_pkg::op_t                sop_r;
  logic [1:0]                  k_r;
  logic [3:0][AW-1:0]          saddr_r;
  logic [AW-1:0]               sld_r;
  logic                        sok_r;
  logic [31:0]                 spix_r;
  logic [abw_pkg::COORD_W-1:0] stx_r, sty_r;

  logic en_b, is_load, step, fin;
  logic [abw_pkg::COORD_W:0] wx, wy;
  logic [2*abw_pkg::COORD_W+1:0] w_full;

  // read return and blend
  logic                        rd_v_r, rd_first_r, rd_last_r;
  logic [abw_pkg::WGT_W-1:0]   rd_w_r;
  logic                        s1_v_r, s1_first_r, s1_last_r;
  logic [abw_pkg::WGT_W-1:0]   s1_w_r;
  logic [7:0]                  s1_a_r;
  logic [abw_pkg::PRD_W-1:0]   s1_p_r [NL];
  logic [abw_pkg::ACC_W-1:0]   acc_r  [NL];
  logic [abw_pkg::ASUM_W-1:0]  asum_r;
  logic                        done_r;
  logic [7:0]                  rd_a;
  logic [abw_pkg::ASUM_W-1:0]  a_rnd;

  // divider
  logic                        dv_r    [0:DS];
  logic [abw_pkg::NUM_W-1:0]   n_r     [0:DS][NL];
  logic [abw_pkg::Q_W-1:0]     q_r     [0:DS][NL];
  logic [abw_pkg::DEN_W-1:0]   d_r     [0:DS];
  logic [7:0]                  alpha_r [0:DS];
  logic                        az_r    [0:DS];
  logic [abw_pkg::NUM_W-1:0]   n_nxt   [1:DS][NL];
  logic [abw_pkg::Q_W-1:0]     q_nxt   [1:DS][NL];

  logic       out_valid_r;
  logic [7:0] out_chan_r [NL];

  assign en_b    = !out_valid_r || !out_stall;
  assign is_load = (sop_r == abw_pkg::OP_LOAD);
  assign step    = busy_r && (is_load || en_b);
  assign fin     = step && (is_load || (k_r == 2'd3));
  assign fe_take = fe.valid && (!busy_r || fin);

  assign mem_we    = busy_r && is_load && sok_r;
  assign mem_re    = busy_r && !is_load && en_b;
  assign mem_addr  = is_load ? sld_r : saddr_r[k_r];
  assign mem_wdata = spix_r;

  // neighbor order: top-left, top-right, bottom-left, bottom-right
  assign wx = k_r[0] ? {1'b0, stx_r} : (9'd256 - {1'b0, stx_r});
  assign wy = k_r[1] ? {1'b0, sty_r} : (9'd256 - {1'b0, sty_r});
  assign w_full = wx * wy;

  assign rd_a  = mem_rdata[8*ALPHA_LANE +: 8];
  assign a_rnd = asum_r + abw_pkg::ASUM_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (fe_take) begin
      busy_r <= 1'b1;
    end else if (fin) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fe_take) begin
      sop_r   <= fe.op;
      k_r     <= '0;
      saddr_r <= fe_addr;
      sld_r   <= fe_ld_addr;
      sok_r   <= fe.ld_ok;
      spix_r  <= fe_pixel;
      stx_r   <= fe_tx;
      sty_r   <= fe_ty;
    end else if (step && !fin) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_comb begin
    logic [abw_pkg::NUM_W-1:0] n;
    logic [abw_pkg::NUM_W-1:0] sd;
    for (int s = 1; s <= DS; s++) begin
      sd = abw_pkg::NUM_W'(d_r[s-1]) << (DS - s);
      for (int c = 0; c < NL; c++) begin
        n = n_r[s-1][c];
        q_nxt[s][c] = q_r[s-1][c];
        if (n >= sd) begin
          n = n - sd;
          q_nxt[s][c][DS - s] = 1'b1;
        end
        n_nxt[s][c] = n;
      end
    end
  end

  // valid flags of the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s <= DS; s++) begin
        dv_r[s] <= 1'b0;
      end
    end else if (en_b) begin
      rd_v_r <= busy_r && !is_load;
      s1_v_r <= rd_v_r;
      done_r <= s1_v_r && s1_last_r;
      dv_r[0] <= done_r;
      for (int s = 1; s <= DS; s++) begin
        dv_r[s] <= dv_r[s-1];
      end
      out_valid_r <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      rd_first_r <= (k_r == 2'd0);
      rd_last_r  <= (k_r == 2'd3);
      rd_w_r     <= w_full[abw_pkg::WGT_W-1:0];

      s1_first_r <= rd_first_r;
      s1_last_r  <= rd_last_r;
      s1_w_r     <= rd_w_r;
      s1_a_r     <= rd_a;
      for (int c = 0; c < NL; c++) begin
        s1_p_r[c] <= mem_rdata[8*c +: 8] * rd_a;
      end

      if (s1_v_r) begin
        for (int c = 0; c < NL; c++) begin
          acc_r[c] <= (s1_first_r ? '0 : acc_r[c]) + s1_w_r * s1_p_r[c];
        end
        asum_r <= (s1_first_r ? '0 : asum_r) + s1_w_r * s1_a_r;
      end

      for (int c = 0; c < NL; c++) begin
        n_r[0][c] <= {acc_r[c], 1'b0} + abw_pkg::NUM_W'(asum_r);
        q_r[0][c] <= '0;
      end
      d_r[0]     <= {asum_r, 1'b0};
      alpha_r[0] <= a_rnd[23:16];
      az_r[0]    <= (asum_r == '0);
      for (int s = 1; s <= DS; s++) begin
        for (int c = 0; c < NL; c++) begin
          n_r[s][c] <= n_nxt[s][c];
          q_r[s][c] <= q_nxt[s][c];
        end
        d_r[s]     <= d_r[s-1];
        alpha_r[s] <= alpha_r[s-1];
        az_r[s]    <= az_r[s-1];
      end

      for (int c = 0; c < NL; c++) begin
        if (c == ALPHA_LANE) begin
          out_chan_r[c] <= alpha_r[DS];
        end else if (az_r[DS]) begin
          out_chan_r[c] <= '0;
        end else begin
          out_chan_r[c] <= q_r[DS][c];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_chan0 = out_chan_r[0];
  assign out_chan1 = out_chan_r[1];
  assign out_chan2 = out_chan_r[2];
  assign out_chan3 = out_chan_r[3];

endmodule

// ===== hdl/abw_checker.sv =====
// Port-level checks for the resampler top, bound to every instance.
module abw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_chan0,
  input logic [7:0] out_chan1,
  input logic [7:0] out_chan2,
  input logic [7:0] out_chan3
);

  logic [7:0] pend_r;
  logic       smp_acc, res_acc;

  assign smp_acc = in_valid && !in_stall && (in_op == abw_pkg::OP_SAMPLE);
  assign res_acc = out_valid && !out_stall;

  // samples taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(smp_acc) - 8'(res_acc);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 8'd0))
    else $error("result word without a pending sample");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_chan0) && $stable(out_chan1)
                               && $stable(out_chan2) && $stable(out_chan3))
    else $error("result word changed while stalled");

endmodule

bind affine_bilinear_wrap_resampler_top abw_checker u_abw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_chan0 (out_chan0),
  .out_chan1 (out_chan1),
  .out_chan2 (out_chan2),
  .out_chan3 (out_chan3)
);

// ===== verif/tb_affine_bilinear_wrap_resampler_top.sv =====
// Testbench for the affine bilinear wrap resampler: random stimulus, inline predictor.
`timescale 1ns / 100ps
module tb_affine_bilinear_wrap_resampler_top;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 60;
  localparam int STORE_N    = 128 * 128;

  typedef struct {
    abw_pkg::op_t       op;
    logic [13:0]        idx;
    logic [31:0]        pix;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = 1'b0;
  logic [13:0]         in_load_index = '0;
  logic [31:0]         in_load_pixel = '0;
  logic signed [15:0]  in_dest_x = '0;
  logic signed [15:0]  in_dest_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_chan0, out_chan1, out_chan2, out_chan3;
  logic                cfg_we = 1'b0;
  logic [abw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [abw_pkg::CFG_DW-1:0]    cfg_wdata = '0;

  affine_bilinear_wrap_resampler_top u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]      img [0:STORE_N-1];
  bit               planned [0:STORE_N-1];
  int               mat [0:5];
  logic [7:0]       w_reg, h_reg;
  word_t            word_q [$];
  logic [3:0][7:0]  pixel_q [$];
  word_t            cur;
  int               in_gap, out_gap, idle_cnt, errors;
  bit               calm;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_size(logic [7:0] s);
    if (s == 0) return 1;
    return (s > 128) ? 128 : int'(s);
  endfunction

  function automatic logic [3:0][7:0] blend_pixel(logic signed [15:0] dx,
                                                  logic signed [15:0] dy);
    longint sx, sy, mx, my, span;
    int w, h, l, t, r, b, tx, ty, k, c;
    logic [31:0] px [4];
    longint unsigned wt [4];
    longint unsigned psum [4];
    longint unsigned asum, v, a, ch;
    logic [3:0][7:0] res;
    w = eff_size(w_reg);
    h = eff_size(h_reg);
    sx = longint'(mat[0]) * longint'(dx) + longint'(mat[1]) * longint'(dy) + longint'(mat[2]);
    sy = longint'(mat[3]) * longint'(dx) + longint'(mat[4]) * longint'(dy) + longint'(mat[5]);
    span = longint'(w) * 65536;
    mx = sx % span;
    if (mx < 0) mx += span;
    span = longint'(h) * 65536;
    my = sy % span;
    if (my < 0) my += span;
    l = int'(mx >>> 16);
    t = int'(my >>> 16);
    tx = int'((mx >>> 8) & 255);
    ty = int'((my >>> 8) & 255);
    r = (l + 1) % w;
    b = (t + 1) % h;
    px[0] = img[t * 128 + l];
    px[1] = img[t * 128 + r];
    px[2] = img[b * 128 + l];
    px[3] = img[b * 128 + r];
    wt[0] = (256 - tx) * (256 - ty);
    wt[1] = tx * (256 - ty);
    wt[2] = (256 - tx) * ty;
    wt[3] = tx * ty;
    asum = 0;
    for (c = 0; c < 4; c++) psum[c] = 0;
    for (k = 0; k < 4; k++) begin
      a = px[k][31:24];
      asum += wt[k] * a;
      for (c = 0; c < 4; c++) begin
        ch = px[k][8*c +: 8];
        psum[c] += wt[k] * ch * a;
      end
    end
    for (c = 0; c < 4; c++) begin
      if (c == 3) v = (asum + 32768) >> 16;
      else if (asum == 0) v = 0;
      else v = (2 * psum[c] + asum) / (2 * asum);
      if (v > 255) v = 255;
      res[c] = v[7:0];
    end
    return res;
  endfunction

  task automatic report_err(string what, int exp_v, int got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin : drv
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (cur.op == abw_pkg::OP_LOAD) img[cur.idx] = cur.pix;
        else pixel_q.push_back(blend_pixel(cur.dx, cur.dy));
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur = word_q.pop_front();
          in_op <= cur.op;
          in_load_index <= cur.idx;
          in_load_pixel <= cur.pix;
          in_dest_x <= cur.dx;
          in_dest_y <= cur.dy;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    logic [3:0][7:0] e;
    logic [3:0][7:0] g;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        g = {out_chan3, out_chan2, out_chan1, out_chan0};
        if (pixel_q.size() == 0) begin
          report_err("unexpected word, chan0", -1, g[0]);
        end else begin
          e = pixel_q.pop_front();
          for (int c = 0; c < 4; c++)
            if (e[c] !== g[c]) report_err($sformatf("chan%0d", c), e[c], g[c]);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("[affine_bilinear_wrap_resampler_top] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    int r;
    p = $urandom;
    r = $urandom_range(3);
    if (r == 0) p[31:24] = 8'h00;
    else if (r == 1) p[31:24] = 8'hFF;
    if ($urandom_range(7) == 0) p[23:0] = ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
    return p;
  endfunction

  task automatic push_load(int idx, logic [31:0] pix);
    word_t wd;
    wd.op = abw_pkg::OP_LOAD;
    wd.idx = idx[13:0];
    wd.pix = pix;
    wd.dx = 16'($urandom);
    wd.dy = 16'($urandom);
    planned[idx] = 1'b1;
    word_q.push_back(wd);
  endtask

  task automatic push_sample(logic signed [15:0] dx, logic signed [15:0] dy);
    word_t wd;
    wd.op = abw_pkg::OP_SAMPLE;
    wd.idx = 14'($urandom);
    wd.pix = $urandom;
    wd.dx = dx;
    wd.dy = dy;
    word_q.push_back(wd);
  endtask

  // every texel of the active tile must be loaded before it can be read
  task automatic fill_tile();
    for (int y = 0; y < eff_size(h_reg); y++)
      for (int x = 0; x < eff_size(w_reg); x++)
        if (!planned[y * 128 + x]) push_load(y * 128 + x, rand_pixel());
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cfg(int m0, int m1, int m2, int m3, int m4, int m5,
                         logic [7:0] w, logic [7:0] h);
    logic [31:0] vals [8];
    vals = '{m0, m1, m2, m3, m4, m5, {24'd0, w}, {24'd0, h}};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[abw_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 6; i++) mat[i] = vals[i];
    w_reg = w;
    h_reg = h;
  endtask

  function automatic int rand_coef();
    int r;
    r = $urandom_range(5);
    if (r == 0) return 0;
    if (r == 1) return $urandom;
    if (r == 2) return ($urandom_range(1) ? 1 : -1) * 65536;
    return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
  endfunction

  initial begin
    logic signed [15:0] ex [4];
    mat = '{65536, 0, 0, 0, 65536, 0};
    w_reg = 8'd128;
    h_reg = 8'd128;
    errors = 0;
    in_gap = 0;
    out_gap = 0;
    idle_cnt = 0;
    calm = 1'b0;
    ex = '{16'sh0000, 16'sh7FFF, -16'sh8000, -16'sd1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // load extremes of address and data
    push_load(0, 32'h0000_0000);
    push_load(STORE_N - 1, 32'hFFFF_FFFF);
    push_load(14'h2AAA, 32'hAAAA_AAAA);
    push_load(14'h1555, 32'h5555_5555);
    drain();

    // wide single-row tile, half-texel shift
    set_cfg(65536, 0, 32'h8000, 0, 65536, 0, 8'd128, 8'd1);
    fill_tile();
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 2; j++) push_sample(ex[i], ex[(i + j) % 4]);
    calm = 1'b1;
    drain();

    // extreme coefficients, zero width clamps to 1, oversize height clamps
    set_cfg(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'h8000_0000, 32'h7FFF_FFFF, 0,
            8'd0, 8'd200);
    calm = 1'b0;
    fill_tile();
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 2; j++) push_sample(ex[j * 2], ex[i]);
    drain();

    // oversize width, zero height
    set_cfg(32'h0001_8000, 32'h0000_4000, 0, 0, 32'h0001_0000, 32'h0000_C000,
            8'd255, 8'd0);
    fill_tile();
    for (int i = 0; i < 4; i++) push_sample(ex[i], ex[3 - i]);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      calm = (ph % 4 == 1);
      set_cfg(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
              8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
      fill_tile();
      for (int n = 0; n < 92; n++) begin
        if ($urandom_range(9) < 7) begin
          push_sample(16'($urandom), 16'($urandom));
        end else if ($urandom_range(1)) begin
          // overwrite a texel inside the tile
          push_load($urandom_range(0, eff_size(h_reg) - 1) * 128
                    + $urandom_range(0, eff_size(w_reg) - 1), rand_pixel());
        end else begin
          push_load($urandom_range(0, STORE_N - 1), rand_pixel());
        end
      end
      drain();
    end

    if (errors == 0) $display("[affine_bilinear_wrap_resampler_top] OK");
    else $display("[affine_bilinear_wrap_resampler_top] ERROR");
    $finish;
  end

endmodule

// ===== affine_bilinear_wrap_resampler_top.f =====
hdl/abw_pkg.sv
hdl/abw_ram.sv
hdl/abw_wrap.sv
hdl/abw_coord.sv
hdl/abw_blend.sv
hdl/affine_bilinear_wrap_resampler_top.sv
hdl/abw_checker.sv
verif/tb_affine_bilinear_wrap_resampler_top.sv
